[sv/fvg_pkg.sv]
// Package for the FAT volume layout pipeline: field widths, codes, beat structs
// and table lookup helpers. No dependencies.
`default_nettype none
package fvg_pkg;
  localparam int SizeBits = 48;

  typedef enum logic [2:0] {
    REQ_AUTO = 3'd0, REQ_AUTO16 = 3'd1, REQ_FAT12 = 3'd2, REQ_FAT16 = 3'd3, REQ_FAT32 = 3'd4
  } fs_req_t;

  localparam logic [1:0] FAT12 = 2'd0;
  localparam logic [1:0] FAT16 = 2'd1;
  localparam logic [1:0] FAT32 = 2'd2;

  typedef struct packed {
    logic [SizeBits-1:0] size_bytes;
    logic [2:0]  fs_request;
    logic        auto_sector_size;
    logic        auto_cluster_size;
    logic        auto_root_entries;
    logic [12:0] sector_bytes_req;
    logic [7:0]  cluster_sectors_req;
    logic [15:0] root_entries_req;
    logic        align_clusters;
    logic        strict_check;
    logic        with_mbr;
    logic        mbr_padded;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  fat_type;
    logic [12:0] sector_bytes;
    logic [7:0]  cluster_sectors;
    logic [39:0] total_sectors;
    logic [27:0] data_clusters;
    logic [22:0] fat_sectors_each;
    logic [7:0]  first_fat_sector;
    logic [12:0] root_dir_sectors;
    logic [23:0] data_area_start;
    logic [7:0]  boot_record_sectors;
    logic [48:0] total_bytes;
  } res_t;

  // Sectors scaled to bytes: sectors << log2(bps); compare against byte limits.
  // log2(cluster bytes) for the tables, given size in bytes (sectors*bps, 53 bits).
  function automatic logic [4:0] tab_log2(input logic [1:0] fs, input logic [52:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (fs == FAT12) begin
      r = (b < 53'd15 * 53'd1048576) ? 5'd13 : 5'd12;
    end else if (fs == FAT16) begin
      if (b < (53'd16 << 20)) r = 5'd12;
      else if (b < (53'd128 << 20)) r = 5'd11;
      else if (b < (53'd256 << 20)) r = 5'd12;
      else if (b < (53'd512 << 20)) r = 5'd13;
      else if (b < (53'd1 << 30)) r = 5'd14;
      else if (b < (53'd2 << 30)) r = 5'd15;
      else if (b < (53'd4 << 30)) r = 5'd16;
      else if (b < (53'd8 << 30)) r = 5'd17;
      else r = 5'd18;
    end else begin
      if (b < (53'd260 << 20)) r = 5'd9;
      else if (b < (53'd8 << 30)) r = 5'd12;
      else if (b < (53'd16 << 30)) r = 5'd13;
      else if (b < (53'd32 << 30)) r = 5'd14;
      else r = 5'd15;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

[sv/fvg_if.sv]
// Valid/ready channel interfaces carrying one beat of type req_t or res_t.
// Depends on fvg_pkg for the payload types.
`default_nettype none
interface fvg_req_if (input wire logic clk);
  import fvg_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fvg_res_if (input wire logic clk);
  import fvg_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/fvg_front.sv]
// Stage 1 and 2: sector size, round up, type and cluster size selection.
// Depends on fvg_pkg.
`default_nettype none
module fvg_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire fvg_pkg::req_t in_req,
  output logic               s2_valid,
  output logic               s2_err,
  output logic [1:0]         s2_fs,
  output logic [3:0]         s2_lbps,
  output logic [2:0]         s2_lspc,
  output logic [39:0]        s2_sectors,
  output fvg_pkg::req_t      s2_req
);
  import fvg_pkg::*;

  logic          s1_valid;
  logic          s1_err;
  logic [3:0]    s1_lbps;
  logic [39:0]   s1_sectors;
  req_t          s1_req;
  logic          err1;
  logic [3:0]    lbps;
  logic [12:0]   sb;
  logic [SizeBits-1:0] sz;
  logic [SizeBits-1:0] msk;
  logic [SizeBits-1:0] q;
  logic [39:0]   s1_sectors_next;

  // Decode sector size and round up the size
  always_comb begin
    err1 = 1'b0;
    lbps = 4'd9;
    sb = in_req.sector_bytes_req;
    if (!in_req.auto_sector_size) begin
      case (sb)
        13'd512:  lbps = 4'd9;
        13'd1024: lbps = 4'd10;
        13'd2048: lbps = 4'd11;
        13'd4096: lbps = 4'd12;
        default:  err1 = 1'b1;
      endcase
    end
    sz = in_req.size_bytes;
    msk = (SizeBits'(1) << lbps) - SizeBits'(1);
    q = sz >> lbps;
    s1_sectors_next = 40'(q) + {39'd0, |(sz & msk)};
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
    if (en) begin
      s1_err <= err1;
      s1_lbps <= lbps;
      s1_sectors <= s1_sectors_next;
      s1_req <= in_req;
    end
  end

  // Select type and cluster size
  logic        err2;
  logic [1:0]  fs;
  logic [2:0]  lspc;
  logic [52:0] bytes;
  logic [4:0]  lc;
  logic [39:0] clus0;
  logic [7:0]  spc;
  always_comb begin
    err2 = s1_err;
    fs = FAT12;
    lspc = 3'd0;
    bytes = 53'(s1_sectors) << s1_lbps;
    spc = s1_req.cluster_sectors_req;
    clus0 = 40'd0;
    lc = 5'd0;
    if (s1_req.auto_cluster_size) begin
      if (s1_req.fs_request == REQ_AUTO || s1_req.fs_request == REQ_AUTO16) begin
        if (bytes < (53'd16 << 20)) fs = FAT12;
        else if (bytes >= (53'd260 << 20) && bytes < (53'd2 << 40)
                 && s1_req.fs_request != REQ_AUTO16) fs = FAT32;
        else if (bytes < (53'd16 << 30)) fs = FAT16;
        else err2 = 1'b1;
      end else if (s1_req.fs_request <= REQ_FAT32) begin
        fs = 2'(s1_req.fs_request - REQ_FAT12);
      end else begin
        err2 = 1'b1;
      end
      lc = tab_log2(fs, bytes);
      if (lc <= 5'(s1_lbps)) lspc = 3'd0;
      else if (lc - 5'(s1_lbps) > 5'd7) err2 = 1'b1;
      else lspc = 3'(lc - 5'(s1_lbps));
    end else begin
      if (spc == 8'd0 || (spc & (spc - 8'd1)) != 8'd0) err2 = 1'b1;
      for (int i = 0; i < 8; i++) if (spc[i]) lspc = 3'(i);
      clus0 = s1_sectors >> lspc;
      if (s1_req.fs_request == REQ_AUTO || s1_req.fs_request == REQ_AUTO16) begin
        if (clus0 < 40'd4085) fs = FAT12;
        else if (clus0 < 40'd65525 || s1_req.fs_request == REQ_AUTO16) fs = FAT16;
        else fs = FAT32;
      end else if (s1_req.fs_request <= REQ_FAT32) begin
        fs = 2'(s1_req.fs_request - REQ_FAT12);
      end else begin
        err2 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
    if (en) begin
      s2_err <= err2;
      s2_fs <= fs;
      s2_lbps <= s1_lbps;
      s2_lspc <= lspc;
      s2_sectors <= s1_sectors;
      s2_req <= s1_req;
    end
  end
endmodule
`default_nettype wire

[sv/fvg_back.sv]
// Stages 3 to 5: root and FAT region sizing, cluster count checks, result.
// Depends on fvg_pkg.
`default_nettype none
module fvg_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          s2_valid,
  input  wire logic          s2_err,
  input  wire logic [1:0]    s2_fs,
  input  wire logic [3:0]    s2_lbps,
  input  wire logic [2:0]    s2_lspc,
  input  wire logic [39:0]   s2_sectors,
  input  wire fvg_pkg::req_t s2_req,
  output logic               out_valid,
  output fvg_pkg::res_t      out_res
);
  import fvg_pkg::*;

  // Stage 3: fixed regions and first cluster estimate
  logic [7:0]  spc2;
  logic [7:0]  fat1;
  logic [15:0] rent;
  logic [20:0] rbytes;
  logic [12:0] rsec;
  logic [12:0] rmask;
  logic [13:0] dst;
  logic        e3;
  logic [39:0] c1;
  always_comb begin
    spc2 = 8'd1 << s2_lspc;
    e3 = s2_err;
    rent = s2_req.auto_root_entries ? 16'd512 : s2_req.root_entries_req;
    rbytes = {rent, 5'd0};
    rmask = 13'(spc2) - 13'd1;
    rsec = 13'(rbytes >> s2_lbps)
           + {12'd0, |(rbytes & ((21'd1 << s2_lbps) - 21'd1))};
    if (s2_fs == FAT32) begin
      fat1 = 8'd32;
      if (s2_req.align_clusters) fat1 = 8'((9'd32 + 9'(spc2)) & ~(9'(spc2) - 9'd1));
      rsec = 13'd0;
    end else begin
      fat1 = s2_req.align_clusters ? spc2 : 8'd1;
      if (s2_req.align_clusters) rsec = (rsec + rmask) & ~rmask;
    end
    dst = 14'(fat1) + 14'(rsec);
    if (40'(dst) > s2_sectors) e3 = 1'b1;
    c1 = (s2_sectors - 40'(dst)) >> s2_lspc;
  end

  logic        s3_valid, s3_err;
  logic [1:0]  s3_fs;
  logic [3:0]  s3_lbps;
  logic [2:0]  s3_lspc;
  logic [39:0] s3_sectors, s3_c1;
  logic [7:0]  s3_fat1;
  logic [12:0] s3_rsec;
  logic [13:0] s3_dst;
  req_t        s3_req;
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
    if (en) begin
      s3_err <= e3; s3_fs <= s2_fs; s3_lbps <= s2_lbps; s3_lspc <= s2_lspc;
      s3_sectors <= s2_sectors; s3_c1 <= c1; s3_fat1 <= fat1; s3_rsec <= rsec;
      s3_dst <= dst; s3_req <= s2_req;
    end
  end

  // Stage 4: table size and final data start
  logic [42:0] fb;
  logic [42:0] fs43;
  logic [42:0] fm;
  logic [43:0] d2;
  always_comb begin
    if (s3_fs == FAT12) fb = ((43'(s3_c1) * 43'd3) >> 1) + 43'd1;
    else if (s3_fs == FAT16) fb = 43'(s3_c1) << 1;
    else fb = 43'(s3_c1) << 2;
    fs43 = (fb >> s3_lbps) + {42'd0, |(fb & ((43'd1 << s3_lbps) - 43'd1))};
    fm = (43'd1 << s3_lspc) - 43'd1;
    if (s3_req.align_clusters) fs43 = (fs43 + fm) & ~fm;
    d2 = 44'(s3_dst) + {fs43, 1'b0};
  end

  logic        s4_valid, s4_err;
  logic [1:0]  s4_fs;
  logic [3:0]  s4_lbps;
  logic [2:0]  s4_lspc;
  logic [39:0] s4_sectors;
  logic [7:0]  s4_fat1;
  logic [12:0] s4_rsec;
  logic [42:0] s4_fsec;
  logic [43:0] s4_d2;
  req_t        s4_req;
  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en) s4_valid <= s3_valid;
    if (en) begin
      s4_err <= s3_err; s4_fs <= s3_fs; s4_lbps <= s3_lbps; s4_lspc <= s3_lspc;
      s4_sectors <= s3_sectors; s4_fat1 <= s3_fat1; s4_rsec <= s3_rsec;
      s4_fsec <= fs43; s4_d2 <= d2; s4_req <= s3_req;
    end
  end

  // Stage 5: final cluster count, limits and result assembly
  logic        e5;
  logic [39:0] cl;
  logic [7:0]  mbr;
  res_t        r;
  always_comb begin
    e5 = s4_err;
    if (s4_d2 > 44'(s4_sectors)) e5 = 1'b1;
    cl = (s4_sectors - 40'(s4_d2)) >> s4_lspc;
    if (s4_fs == FAT12) begin
      if (cl > 40'd4084) e5 = 1'b1;
    end else if (s4_fs == FAT16) begin
      if (cl < 40'd4085 || cl > 40'd65524) e5 = 1'b1;
    end else begin
      if (cl < 40'd65525 || (s4_req.strict_check && cl == 40'd65525)) e5 = 1'b1;
      if (cl > 40'hfffffed) e5 = 1'b1;
    end
    mbr = !s4_req.with_mbr ? 8'd0 : (s4_req.mbr_padded ? (8'd1 << s4_lspc) : 8'd1);
    r = '0;
    r.status = 1'b1;
    if (!e5) begin
      r.status = 1'b0;
      r.fat_type = s4_fs;
      r.sector_bytes = 13'd1 << s4_lbps;
      r.cluster_sectors = 8'd1 << s4_lspc;
      r.total_sectors = s4_sectors;
      r.data_clusters = 28'(cl);
      r.fat_sectors_each = 23'(s4_fsec);
      r.first_fat_sector = s4_fat1;
      r.root_dir_sectors = s4_rsec;
      r.data_area_start = 24'(s4_d2);
      r.boot_record_sectors = mbr;
      r.total_bytes = 49'((53'(s4_sectors) + 53'(mbr)) << s4_lbps);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s4_valid;
    if (en) out_res <= r;
  end

  // An error beat carries zeros in every other field
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status |-> out_res.total_sectors == 40'd0 && out_res.fat_type == 2'd0)
    else $error("error beat with payload");
  // A good beat has a legal type and nonzero cluster size
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.status |-> out_res.fat_type != 2'd3 && out_res.cluster_sectors != 8'd0)
    else $error("bad good beat");
  // Stalled pipeline holds its output stage
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid)) else $error("output moved while stalled");
endmodule
`default_nettype wire

[sv/fat_volume_geometry_core.sv]
// FAT volume layout pipeline top level: request channel in, layout channel out.
// Depends on fvg_pkg, fvg_if, fvg_front and fvg_back.
`default_nettype none
// Takes one volume request per cycle unless stalled and returns its FAT12/16/32
// layout through a five stage pipeline (decode and round up, type and cluster
// size, fixed regions, table size, limits). A request whose result cannot be
// taken stalls the whole pipeline; the last stage doubles as the output
// register, so a new request enters whenever that register is free or being
// drained. Errors return status 1 with all other fields zero.
module fat_volume_geometry_core (
  input wire logic    clk,
  input wire logic    rst,
  fvg_req_if.sink     req,
  fvg_res_if.source   res
);
  import fvg_pkg::*;

  logic        en;
  logic        s2_valid, s2_err;
  logic [1:0]  s2_fs;
  logic [3:0]  s2_lbps;
  logic [2:0]  s2_lspc;
  logic [39:0] s2_sectors;
  req_t        s2_req;

  // Advance whenever the output is empty or being drained
  assign en = !res.valid || res.ready;
  assign req.ready = en;

  fvg_front u_front (
    .clk, .rst, .en,
    .in_valid(req.valid), .in_req(req.data),
    .s2_valid, .s2_err, .s2_fs, .s2_lbps, .s2_lspc, .s2_sectors, .s2_req
  );

  fvg_back u_back (
    .clk, .rst, .en,
    .s2_valid, .s2_err, .s2_fs, .s2_lbps, .s2_lspc, .s2_sectors, .s2_req,
    .out_valid(res.valid), .out_res(res.data)
  );
endmodule
`default_nettype wire
